FILE: hdl/ptb_pkg.sv
package ptb_pkg;

    // Most results one tick transaction reports; further fires update state silently.
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned RES_BITS    = 5;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ADD_PER = 2'd1,
        CMD_ADD_ONE = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_RD,
        ST_EV
    } t_state;

endpackage

FILE: hdl/ptb_ram.sv
module ptb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ptb_alu.sv
module ptb_alu #(
    parameter int TICK_BITS = 32
) (
    input  logic [TICK_BITS-1:0] i_tick,
    input  logic [TICK_BITS-1:0] i_last_fired,
    input  logic [31:0]          i_period,
    input  logic [31:0]          i_fires,
    output logic                 o_due,
    output logic [31:0]          o_fires_inc
);

    localparam int CW = (TICK_BITS > 32) ? TICK_BITS : 32;

    logic [TICK_BITS-1:0] w_elapsed;
    logic [CW-1:0]        w_elapsed_ext;
    logic [CW-1:0]        w_period_ext;

    // Modular difference handles counter wrap between the last fire and now.
    assign w_elapsed     = i_tick - i_last_fired;
    assign w_elapsed_ext = CW'(w_elapsed);
    assign w_period_ext  = CW'(i_period);
    assign o_due         = (w_elapsed_ext >= w_period_ext);
    assign o_fires_inc   = i_fires + 32'd1;

endmodule

FILE: hdl/periodic_oneshot_timer_bank_unit.sv
// Add transaction: scans for the first free slot and reports its one result, added or full.
// Busy stays high until that result is on the strobe.
// Tick transaction: a periodic pass and then a one-shot pass, each with one slot lookup per
// slot plus one RAM read and evaluate step per armed slot of that pass.
// Reserved command: one result on the next cycle; busy never rises.
// The receiver cannot stall: every result is valid for exactly one cycle on o_strobe.
// Synchronous active-low reset clears the tick counter, all slot valid bits and the sequencer.
module periodic_oneshot_timer_bank_unit
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_period_ticks,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic        o_one_shot,
    output logic [31:0] o_fire_count,
    output logic [31:0] o_tick_now,
    output logic        o_last
);

    // Slot index width, scan counter width (it must hold NUM_TIMERS to flag the end of a
    // pass), and padded widths used to take the low bits for the result ports.
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int SW = (IW > 4) ? IW : 4;
    localparam int TW = (TICK_BITS > 32) ? TICK_BITS : 32;

    // Sequencer and control state.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_group, n_group;      // 0 = periodic pass, 1 = one-shot pass
    logic [RES_BITS-1:0]   r_nres, n_nres;        // results reported so far in this tick
    logic                  r_pend_v, n_pend_v;    // a fire result is held back
    logic [TICK_BITS-1:0]  r_tick, n_tick;
    logic [NUM_TIMERS-1:0] r_valid, n_valid;
    logic                  r_out_v, n_out_v;

    // Payload registers, no reset needed.
    logic [NUM_TIMERS-1:0] r_os, n_os;
    logic                  r_req_os, n_req_os;
    logic [31:0]           r_period, n_period;
    logic [3:0]            r_pend_slot, n_pend_slot;
    logic                  r_pend_os, n_pend_os;
    logic [31:0]           r_pend_cnt, n_pend_cnt;
    t_kind                 r_o_kind, n_o_kind;
    logic [3:0]            r_o_slot, n_o_slot;
    logic                  r_o_os, n_o_os;
    logic [31:0]           r_o_cnt, n_o_cnt;
    logic                  r_o_last, n_o_last;

    // Datapath wiring.
    logic [IW-1:0]         w_idx;
    logic [SW-1:0]         w_slot_ext;
    logic [3:0]            w_slot;
    logic [TW-1:0]         w_tick_ext;
    logic                  w_scan_end;
    logic                  w_we_add;
    logic                  w_we_fire;
    logic [31:0]           w_rd_period;
    logic [TICK_BITS-1:0]  w_rd_last;
    logic [31:0]           w_rd_fires;
    logic [31:0]           w_fires_inc;
    logic [31:0]           w_fires_wdata;
    logic                  w_due;

    assign w_idx      = r_cnt[IW-1:0];
    assign w_slot_ext = SW'(w_idx);
    assign w_slot     = w_slot_ext[3:0];
    assign w_tick_ext = TW'(r_tick);
    assign w_scan_end = (r_cnt == CW'(NUM_TIMERS));

    // Per-slot period, last-fired tick and fire count live in RAMs addressed by the scan
    // counter. The read issued during the lookup cycle is ready in the evaluate cycle.
    assign w_fires_wdata = w_we_fire ? w_fires_inc : 32'd0;

    ptb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_add),
        .i_addr  (w_idx),
        .i_wdata (r_period),
        .o_rdata (w_rd_period)
    );

    ptb_ram #(.WIDTH(TICK_BITS), .DEPTH(NUM_TIMERS)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_add | w_we_fire),
        .i_addr  (w_idx),
        .i_wdata (r_tick),
        .o_rdata (w_rd_last)
    );

    ptb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_fires_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_add | w_we_fire),
        .i_addr  (w_idx),
        .i_wdata (w_fires_wdata),
        .o_rdata (w_rd_fires)
    );

    // The one shared unit: wrap-safe elapsed compare and fire count increment.
    ptb_alu #(.TICK_BITS(TICK_BITS)) u_alu (
        .i_tick       (r_tick),
        .i_last_fired (w_rd_last),
        .i_period     (w_rd_period),
        .i_fires      (w_rd_fires),
        .o_due        (w_due),
        .o_fires_inc  (w_fires_inc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_group  <= 1'b0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
            r_tick   <= '0;
            r_valid  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_group  <= n_group;
            r_nres   <= n_nres;
            r_pend_v <= n_pend_v;
            r_tick   <= n_tick;
            r_valid  <= n_valid;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_os        <= n_os;
        r_req_os    <= n_req_os;
        r_period    <= n_period;
        r_pend_slot <= n_pend_slot;
        r_pend_os   <= n_pend_os;
        r_pend_cnt  <= n_pend_cnt;
        r_o_kind    <= n_o_kind;
        r_o_slot    <= n_o_slot;
        r_o_os      <= n_o_os;
        r_o_cnt     <= n_o_cnt;
        r_o_last    <= n_o_last;
    end

    // Sequencer. A fire result is held in the pending register until the next fire or the
    // end of the scan, so that the final result of a tick can carry the last flag.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_group     = r_group;
        n_nres      = r_nres;
        n_pend_v    = r_pend_v;
        n_tick      = r_tick;
        n_valid     = r_valid;
        n_out_v     = 1'b0;
        n_os        = r_os;
        n_req_os    = r_req_os;
        n_period    = r_period;
        n_pend_slot = r_pend_slot;
        n_pend_os   = r_pend_os;
        n_pend_cnt  = r_pend_cnt;
        n_o_kind    = r_o_kind;
        n_o_slot    = r_o_slot;
        n_o_os      = r_o_os;
        n_o_cnt     = r_o_cnt;
        n_o_last    = r_o_last;
        w_we_add    = 1'b0;
        w_we_fire   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cnt = '0;
                    case (t_cmd'(i_cmd))
                        CMD_TICK: begin
                            n_tick   = r_tick + TICK_BITS'(1);
                            n_group  = 1'b0;
                            n_nres   = '0;
                            n_pend_v = 1'b0;
                            n_state  = ST_RD;
                        end
                        CMD_ADD_PER, CMD_ADD_ONE: begin
                            n_req_os = (t_cmd'(i_cmd) == CMD_ADD_ONE);
                            n_period = i_period_ticks;
                            n_state  = ST_ADD_SCAN;
                        end
                        default: begin
                            // The reserved command reports nothing fired and changes nothing.
                            n_out_v  = 1'b1;
                            n_o_kind = KIND_NONE;
                            n_o_slot = 4'd0;
                            n_o_os   = 1'b0;
                            n_o_cnt  = 32'd0;
                            n_o_last = 1'b1;
                        end
                    endcase
                end
            end

            ST_ADD_SCAN: begin
                if (w_scan_end) begin
                    n_out_v  = 1'b1;
                    n_o_kind = KIND_FULL;
                    n_o_slot = 4'd0;
                    n_o_os   = r_req_os;
                    n_o_cnt  = 32'd0;
                    n_o_last = 1'b1;
                    n_state  = ST_IDLE;
                end else if (!r_valid[w_idx]) begin
                    w_we_add       = 1'b1;
                    n_valid[w_idx] = 1'b1;
                    n_os[w_idx]    = r_req_os;
                    n_out_v        = 1'b1;
                    n_o_kind       = KIND_ADDED;
                    n_o_slot       = w_slot;
                    n_o_os         = r_req_os;
                    n_o_cnt        = 32'd0;
                    n_o_last       = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            ST_RD: begin
                if (w_scan_end) begin
                    if (!r_group) begin
                        n_group = 1'b1;
                        n_cnt   = '0;
                    end else begin
                        n_out_v  = 1'b1;
                        n_o_last = 1'b1;
                        if (r_pend_v) begin
                            n_o_kind = KIND_FIRED;
                            n_o_slot = r_pend_slot;
                            n_o_os   = r_pend_os;
                            n_o_cnt  = r_pend_cnt;
                        end else begin
                            n_o_kind = KIND_NONE;
                            n_o_slot = 4'd0;
                            n_o_os   = 1'b0;
                            n_o_cnt  = 32'd0;
                        end
                        n_pend_v = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end else if (r_valid[w_idx] && (r_os[w_idx] == r_group)) begin
                    n_state = ST_EV;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            ST_EV: begin
                if (w_due) begin
                    w_we_fire = 1'b1;
                    if (r_group) begin
                        n_valid[w_idx] = 1'b0;
                    end
                    if (r_nres < RES_BITS'(MAX_RESULTS)) begin
                        if (r_pend_v) begin
                            n_out_v  = 1'b1;
                            n_o_kind = KIND_FIRED;
                            n_o_slot = r_pend_slot;
                            n_o_os   = r_pend_os;
                            n_o_cnt  = r_pend_cnt;
                            n_o_last = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = w_slot;
                        n_pend_os   = r_group;
                        n_pend_cnt  = w_fires_inc;
                        n_nres      = r_nres + RES_BITS'(1);
                    end
                end
                n_cnt   = r_cnt + CW'(1);
                n_state = ST_RD;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_out_v;
    assign o_kind       = r_o_kind;
    assign o_slot       = r_o_slot;
    assign o_one_shot   = r_o_os;
    assign o_fire_count = r_o_cnt;
    assign o_tick_now   = w_tick_ext[31:0];
    assign o_last       = r_o_last;

endmodule
